[hdl/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))

`endif

[hdl/sss_pkg.sv]
// Package for the segmented stack set: field widths, parameter defaults,
// command, status and sequencer state codes. No dependencies.
package sss_pkg;

  localparam int DEF_NUM_STACKS  = 8;
  localparam int DEF_STACK_DEPTH = 8;
  localparam int DEF_DATA_WIDTH  = 32;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 3;
  localparam int STATUS_W = 2;
  localparam int COLUMN_W = 3;
  localparam int COUNT_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_POPAT = 2'd2,
    CMD_PEEK  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SETTLE
  } state_e;

endpackage

[hdl/sss_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/segmented_stack_set_core.sv]
// Segmented stack set: a stack built from NUM_STACKS sub-stacks of STACK_DEPTH words.
// Push and rejected commands pass the execute and settle states; pop, pop-at and peek
// also pass the read state, and settle steps down past each emptied sub-stack.
// A new command is taken only in the idle state, after the previous result has been
// loaded into the output register when the output is free. Reset clears the counts
// and current sub-stack at once; the value RAM is not cleared. Uses sss_pkg, sss_ram.
`include "assert_macros.svh"

module segmented_stack_set_core #(
  parameter int NUM_STACKS  = sss_pkg::DEF_NUM_STACKS,
  parameter int STACK_DEPTH = sss_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = sss_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sss_pkg::CMD_W-1:0]           command_i,
  input  logic signed [sss_pkg::VALUE_W-1:0]  value_i,
  input  logic [sss_pkg::INDEX_W-1:0]         stack_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sss_pkg::STATUS_W-1:0]        status_o,
  output logic signed [sss_pkg::VALUE_W-1:0]  data_o,
  output logic [sss_pkg::COLUMN_W-1:0]        current_column_o,
  output logic [sss_pkg::COUNT_W-1:0]         column_count_o
);
  import sss_pkg::*;

  localparam int COL_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int MEM_D    = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W   = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int CMP_W    = (COL_W > INDEX_W) ? COL_W : INDEX_W;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_STACKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  state_e state_q, state_d;

  cmd_e                 cmd_q, cmd_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [INDEX_W-1:0]   idx_q, idx_d;
  status_e              res_status_q, res_status_d;
  logic [VALUE_W-1:0]   res_data_q, res_data_d;

  logic [CNT_W-1:0]     cnt_q [NUM_STACKS];
  logic [COL_W-1:0]     active_q, active_d;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [VALUE_W-1:0]   out_data_q, out_data_d;
  logic [COLUMN_W-1:0]  out_col_q, out_col_d;
  logic [COUNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic [COL_W-1:0]     cnt_addr;
  logic [CNT_W-1:0]     cnt_rd;
  logic                 cnt_we;
  logic [COL_W-1:0]     cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [COL_W-1:0]     col_sel;
  logic [CNT_W-1:0]     pos_sel;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                 in_fire;
  logic                 out_free;
  logic                 is_full;
  logic                 is_empty;
  logic                 idx_ok;
  logic                 push_full;
  logic                 exec_err;
  logic                 exec_read;
  logic                 settle_step;
  logic [COL_W-1:0]     col_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign idx_ok   = CMP_W'(idx_q) <= CMP_W'(active_q);
  assign cnt_addr = (state_q == S_EXEC && cmd_q == CMD_POPAT && idx_ok) ?
                    COL_W'(idx_q) : active_q;
  assign cnt_rd   = cnt_q[cnt_addr];

  assign is_full     = (cnt_rd == FULL_CNT);
  assign is_empty    = (cnt_rd == '0);
  assign push_full   = (active_q == LAST_COL) && is_full;
  assign settle_step = (active_q != '0) && is_empty;
  assign col_next    = is_full ? active_q + COL_W'(1) : active_q;

  always_comb begin
    case (cmd_q)
      CMD_PUSH:  exec_err = push_full;
      CMD_POPAT: exec_err = !idx_ok || is_empty;
      default:   exec_err = is_empty;
    endcase
  end
  assign exec_read = (cmd_q != CMD_PUSH) && !exec_err;

  assign ram_addr = ADDR_W'(col_sel) * ADDR_W'(STACK_DEPTH) + ADDR_W'(pos_sel);

  sss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MEM_D)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (DATA_WIDTH'(val_q)),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = exec_read ? S_READ : S_SETTLE;
      end
      S_READ: begin
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        if (!settle_step && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d        = cmd_q;
    val_d        = val_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    active_d     = active_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_col_d    = out_col_q;
    out_cnt_d    = out_cnt_q;
    cnt_we       = 1'b0;
    cnt_waddr    = cnt_addr;
    cnt_wdata    = cnt_rd - CNT_W'(1);
    ram_we       = 1'b0;
    col_sel      = cnt_addr;
    pos_sel      = cnt_rd - CNT_W'(1);
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d        = cmd_e'(command_i);
          val_d        = value_i;
          idx_d        = stack_index_i;
          res_status_d = ST_OK;
          res_data_d   = '0;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_PUSH: begin
            if (push_full) begin
              res_status_d = ST_FULL;
            end else begin
              col_sel   = col_next;
              pos_sel   = is_full ? '0 : cnt_rd;
              ram_we    = 1'b1;
              cnt_we    = 1'b1;
              cnt_waddr = col_next;
              cnt_wdata = is_full ? CNT_W'(1) : cnt_rd + CNT_W'(1);
              active_d  = col_next;
            end
          end
          CMD_POPAT: begin
            if (exec_err) res_status_d = ST_BADIDX;
            else cnt_we = 1'b1;
          end
          CMD_POP: begin
            if (exec_err) res_status_d = ST_EMPTY;
            else cnt_we = 1'b1;
          end
          default: begin
            if (exec_err) res_status_d = ST_EMPTY;
          end
        endcase
      end
      S_READ: begin
        res_data_d = VALUE_W'($signed(ram_rdata));
      end
      S_SETTLE: begin
        if (settle_step) begin
          active_d = active_q - COL_W'(1);
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_col_d    = COLUMN_W'(active_q);
          out_cnt_d    = COUNT_W'(cnt_rd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cnt_we) begin
        cnt_q[cnt_waddr] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_col_q    <= out_col_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign data_o           = out_data_q;
  assign current_column_o = out_col_q;
  assign column_count_o   = out_cnt_q;

  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !in_ready_o)
  `ASSERT_NEVER(a_count_overflow, cnt_rd > FULL_CNT)
  `ASSERT_CLK(a_error_data_zero, out_valid_o && status_o != ST_OK |-> data_o == '0)
  `ASSERT_CLK(a_settled_column, state_q == S_IDLE && active_q != '0 |-> !is_empty)

endmodule
